FILE: rtl/sorted_time_queue_top_defines.svh
// Assertion macros shared by the sorted time queue checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef SORTED_TIME_QUEUE_TOP_DEFINES_SVH
`define SORTED_TIME_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define STQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stq_pkg.sv
// Shared constants for the sorted time queue: command and status codes,
// fixed field widths. No dependencies.
package stq_pkg;

  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int TIME_W     = 32;
  localparam int TAG_PORT_W = 16;
  localparam int OFF_W      = 7;
  localparam int CNT_PORT_W = 7;

  // Commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

FILE: rtl/stq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/stq_offset.sv
// Resolves a signed position offset against the stored entry count into
// a table index and a hit flag. Uses stq_pkg for field widths.
module stq_offset #(
  parameter int DEPTH = 64
) (
  input  logic [$clog2(DEPTH+1)-1:0]     cnt,
  input  logic signed [stq_pkg::OFF_W-1:0] offset,
  output logic                           hit,
  output logic [$clog2(DEPTH)-1:0]       idx
);
  import stq_pkg::*;

  logic signed [31:0] off_s;
  logic signed [31:0] cnt_s;
  logic signed [31:0] back_s;
  logic signed [31:0] pos_s;

  assign off_s  = 32'(offset);
  assign cnt_s  = 32'(cnt);
  assign back_s = -off_s;

  // Forward offsets count from the earliest entry; negative ones count back
  // from the latest and never wrap onto the earliest.
  always_comb begin
    if (off_s >= 0) begin
      hit   = (off_s < cnt_s);
      pos_s = off_s;
    end else begin
      hit   = (cnt_s != 0) && (back_s <= cnt_s - 1);
      pos_s = cnt_s - back_s;
    end
  end

  assign idx = pos_s[$clog2(DEPTH)-1:0];

endmodule

FILE: rtl/sorted_time_queue_top.sv
// Sorted time queue: (time, tag) entries in ascending time order in one RAM; uses stq_pkg,
// stq_ram, stq_offset. Full, miss, empty insert and delete of latest settle without a
// scan; peek reads one row; find scans up from the earliest entry to the match; insert
// shifts later entries up; delete moves the entries after the removed one down.
// One item at a time: the next is accepted once the result enters the output register.
// Reset (synchronous, rst_n low) empties the table; RAM contents are not cleared.
module sorted_time_queue_top #(
  parameter int DEPTH    = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [stq_pkg::CMD_W-1:0]          in_command,
  input  logic [stq_pkg::TIME_W-1:0]         in_departure_time,
  input  logic [stq_pkg::TAG_PORT_W-1:0]     in_entry_tag,
  input  logic signed [stq_pkg::OFF_W-1:0]   in_position_offset,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [stq_pkg::STATUS_W-1:0]       out_status,
  output logic [stq_pkg::TIME_W-1:0]         out_found_time,
  output logic [stq_pkg::TAG_PORT_W-1:0]     out_found_tag,
  output logic [stq_pkg::CNT_PORT_W-1:0]     out_entry_count
);
  import stq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = TIME_W + TAG_BITS;
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [TIME_W-1:0]   key_r, key_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]       last_r, last_nxt;
  logic                up_r, up_nxt;
  logic                more_r, more_nxt;
  logic                rv_r, rv_nxt;
  logic [AW-1:0]       ra_r, ra_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [TIME_W-1:0]   res_time_r, res_time_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;
  logic [TAG_PORT_W-1:0] out_tag_r, out_tag_nxt;
  logic [CNT_PORT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic                accept;
  logic [31:0]         tag_in_ext;
  logic [TAG_BITS-1:0] tag_new;
  logic [CW-1:0]       cnt_m1;
  logic                off_hit;
  logic [AW-1:0]       off_idx;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [MW-1:0]       ram_wdata, ram_rdata;
  logic [TIME_W-1:0]   rd_time;
  logic [TAG_BITS-1:0] rd_tag;
  logic [31:0]         res_tag_ext;
  logic [31:0]         cnt_ext;
  logic                out_load;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign tag_in_ext = 32'(in_entry_tag);
  assign tag_new    = tag_in_ext[TAG_BITS-1:0];
  assign cnt_m1     = cnt_r - CW'(1);
  assign rd_time    = ram_rdata[MW-1:TAG_BITS];
  assign rd_tag     = ram_rdata[TAG_BITS-1:0];
  assign res_tag_ext = 32'(res_tag_r);
  assign cnt_ext    = 32'(cnt_r);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  stq_offset #(.DEPTH(DEPTH)) u_offset (
    .cnt    (cnt_r),
    .offset (in_position_offset),
    .hit    (off_hit),
    .idx    (off_idx)
  );

  // Entry table: {time, tag} per row
  stq_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Command sequencer: start, scan with one read per cycle, finish
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    tag_nxt        = tag_r;
    cnt_nxt        = cnt_r;
    rd_ptr_nxt     = rd_ptr_r;
    last_nxt       = last_r;
    up_nxt         = up_r;
    more_nxt       = more_r;
    res_status_nxt = res_status_r;
    res_time_nxt   = res_time_r;
    res_tag_nxt    = res_tag_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = rd_ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_command;
          key_nxt        = in_departure_time;
          tag_nxt        = tag_new;
          res_status_nxt = ST_NOT_FOUND;
          res_time_nxt   = '0;
          res_tag_nxt    = '0;
          more_nxt       = 1'b0;
          state_nxt      = S_DONE;
          unique case (in_command)
            CMD_INSERT: begin
              if (cnt_r == CNT_FULL) begin
                res_status_nxt = ST_FULL;
              end else if (cnt_r == '0) begin
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata      = {in_departure_time, tag_new};
                cnt_nxt        = cnt_r + CW'(1);
                res_status_nxt = ST_OK;
              end else begin
                // walk down from the latest entry, shifting later times up
                rd_ptr_nxt = cnt_m1[AW-1:0];
                last_nxt   = '0;
                up_nxt     = 1'b0;
                more_nxt   = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            CMD_PEEK: begin
              if (off_hit) begin
                rd_ptr_nxt = off_idx;
                last_nxt   = off_idx;
                up_nxt     = 1'b1;
                more_nxt   = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            CMD_FIND: begin
              if (cnt_r != '0) begin
                rd_ptr_nxt = '0;
                last_nxt   = cnt_m1[AW-1:0];
                up_nxt     = 1'b1;
                more_nxt   = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            CMD_DELETE: begin
              if (off_hit) begin
                if (off_idx == cnt_m1[AW-1:0]) begin
                  // latest entry: nothing to close up
                  cnt_nxt        = cnt_m1;
                  res_status_nxt = ST_OK;
                end else begin
                  rd_ptr_nxt = off_idx + AW'(1);
                  last_nxt   = cnt_m1[AW-1:0];
                  up_nxt     = 1'b1;
                  more_nxt   = 1'b1;
                  state_nxt  = S_SCAN;
                end
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue side
        if (more_r) begin
          ram_re = 1'b1;
          if (rd_ptr_r == last_r) begin
            more_nxt = 1'b0;
          end else if (up_r) begin
            rd_ptr_nxt = rd_ptr_r + AW'(1);
          end else begin
            rd_ptr_nxt = rd_ptr_r - AW'(1);
          end
        end
        // return side: read data for address ra_r
        if (rv_r) begin
          unique case (cmd_r)
            CMD_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = ra_r + AW'(1);
              if (rd_time > key_r) begin
                ram_wdata = ram_rdata;
                if (ra_r == '0) begin
                  state_nxt = S_FIN;
                end
              end else begin
                ram_wdata      = {key_r, tag_r};
                cnt_nxt        = cnt_r + CW'(1);
                res_status_nxt = ST_OK;
                state_nxt      = S_DONE;
              end
            end
            CMD_PEEK: begin
              res_status_nxt = ST_OK;
              res_time_nxt   = rd_time;
              res_tag_nxt    = rd_tag;
              state_nxt      = S_DONE;
            end
            CMD_FIND: begin
              if (rd_time == key_r) begin
                res_status_nxt = ST_OK;
                res_time_nxt   = rd_time;
                res_tag_nxt    = rd_tag;
                state_nxt      = S_DONE;
              end else if (ra_r == last_r) begin
                state_nxt = S_DONE;
              end
            end
            CMD_DELETE: begin
              ram_we    = 1'b1;
              ram_waddr = ra_r - AW'(1);
              ram_wdata = ram_rdata;
              if (ra_r == last_r) begin
                cnt_nxt        = cnt_m1;
                res_status_nxt = ST_OK;
                state_nxt      = S_DONE;
              end
            end
          endcase
        end
      end

      S_FIN: begin
        // every stored time was later: new entry goes to the head
        ram_we         = 1'b1;
        ram_waddr      = '0;
        ram_wdata      = {key_r, tag_r};
        cnt_nxt        = cnt_r + CW'(1);
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  assign rv_nxt = (state_r == S_SCAN) && more_r;
  assign ra_nxt = rd_ptr_r;

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_time_nxt   = out_time_r;
    out_tag_nxt    = out_tag_r;
    out_cnt_nxt    = out_cnt_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_time_nxt   = res_time_r;
      out_tag_nxt    = res_tag_ext[TAG_PORT_W-1:0];
      out_cnt_nxt    = cnt_ext[CNT_PORT_W-1:0];
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      more_r      <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      more_r      <= more_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan pointers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    tag_r        <= tag_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    last_r       <= last_nxt;
    up_r         <= up_nxt;
    ra_r         <= ra_nxt;
    res_status_r <= res_status_nxt;
    res_time_r   <= res_time_nxt;
    res_tag_r    <= res_tag_nxt;
    out_status_r <= out_status_nxt;
    out_time_r   <= out_time_nxt;
    out_tag_r    <= out_tag_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_time  = out_time_r;
  assign out_found_tag   = out_tag_r;
  assign out_entry_count = out_cnt_r;

endmodule

FILE: rtl/stq_checker.sv
// Port-level checks for the sorted time queue, bound to the top level.
// Depends on stq_pkg and sorted_time_queue_top_defines.svh.
`include "sorted_time_queue_top_defines.svh"

module stq_checker #(
  parameter int DEPTH = 64
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [stq_pkg::STATUS_W-1:0]       out_status,
  input logic [stq_pkg::TIME_W-1:0]         out_found_time,
  input logic [stq_pkg::TAG_PORT_W-1:0]     out_found_tag,
  input logic [stq_pkg::CNT_PORT_W-1:0]     out_entry_count
);
  import stq_pkg::*;

  // a stalled result holds
  `STQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_found_time) && $stable(out_found_tag) && $stable(out_entry_count), "stalled result changed")

  // one item in flight: an accepted item blocks the input the next cycle
  `STQ_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "input not blocked after accept")

  // only defined status codes
  `STQ_ASSERT_NOW(a_status_code, out_valid, out_status == ST_OK || out_status == ST_NOT_FOUND || out_status == ST_FULL, "undefined status")

  // failures and full reports carry zero fields
  `STQ_ASSERT_NOW(a_fail_zero, out_valid && out_status != ST_OK, out_found_time == '0 && out_found_tag == '0, "nonzero fields on failed item")

  // full is only reported with the table at capacity
  `STQ_ASSERT_NOW(a_full_count, out_valid && out_status == ST_FULL, out_entry_count == CNT_PORT_W'(DEPTH), "full reported below capacity")

endmodule

bind sorted_time_queue_top stq_checker #(.DEPTH(DEPTH)) u_stq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found_time  (out_found_time),
  .out_found_tag   (out_found_tag),
  .out_entry_count (out_entry_count)
);

FILE: dv/tb_sorted_time_queue_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_time_queue_top: random and directed
// insert/peek/find/delete items checked against a local sorted-table predictor.
// Depends on stq_pkg and the sorted_time_queue_top RTL.
module tb_sorted_time_queue_top;
  import stq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int TAG_BITS    = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS  = 50;

  // Command mix for the random part
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [TIME_W-1:0]        dtime;
    logic [TAG_PORT_W-1:0]    tag;
    logic signed [OFF_W-1:0]  off;
  } queue_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [TIME_W-1:0]     ftime;
    logic [TAG_PORT_W-1:0] ftag;
    logic [CNT_PORT_W-1:0] count;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_command = CMD_PEEK;
  logic [TIME_W-1:0] in_departure_time = '0;
  logic [TAG_PORT_W-1:0] in_entry_tag = '0;
  logic signed [OFF_W-1:0] in_position_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TIME_W-1:0] out_found_time;
  logic [TAG_PORT_W-1:0] out_found_tag;
  logic [CNT_PORT_W-1:0] out_entry_count;

  // Predicted table contents, kept sorted by time
  logic [TIME_W-1:0]     sched_time [DEPTH];
  logic [TAG_PORT_W-1:0] sched_tag  [DEPTH];
  int entry_total = 0;

  queue_cmd_t    pending_cmds[$];
  queue_result_t expected_results[$];
  queue_cmd_t    next_cmd;

  int queued_items = 0;
  int accepted_items = 0;
  int results_seen = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet_stretch;

  assign quiet_stretch = (results_seen >= 500) && (results_seen < 650);

  sorted_time_queue_top #(
    .DEPTH(DEPTH),
    .TAG_BITS(TAG_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_departure_time(in_departure_time),
    .in_entry_tag(in_entry_tag),
    .in_position_offset(in_position_offset),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_found_time(out_found_time),
    .out_found_tag(out_found_tag),
    .out_entry_count(out_entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Map a signed position onto a table index; 0 when it cannot be reached
  function automatic bit locate_slot(input logic signed [OFF_W-1:0] off, output int idx);
    int back;
    idx = 0;
    if (entry_total == 0) return 1'b0;
    if (off >= 0) begin
      if (int'(off) >= entry_total) return 1'b0;
      idx = int'(off);
      return 1'b1;
    end
    back = -int'(off);
    if (back > entry_total - 1) return 1'b0;
    idx = entry_total - back;
    return 1'b1;
  endfunction

  // Apply one command to the predicted table and queue the result it gives
  task automatic apply_command(input queue_cmd_t c);
    queue_result_t r;
    int pos;
    int idx;
    int i;
    r.status = ST_NOT_FOUND;
    r.ftime = '0;
    r.ftag = '0;
    case (c.cmd)
      CMD_INSERT: begin
        if (entry_total >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = entry_total;
          for (i = 0; i < entry_total; i++) begin
            if (sched_time[i] > c.dtime) begin
              pos = i;
              break;
            end
          end
          for (i = entry_total; i > pos; i--) begin
            sched_time[i] = sched_time[i-1];
            sched_tag[i] = sched_tag[i-1];
          end
          sched_time[pos] = c.dtime;
          sched_tag[pos] = c.tag;
          entry_total++;
          r.status = ST_OK;
        end
      end
      CMD_PEEK: begin
        if (locate_slot(c.off, idx)) begin
          r.status = ST_OK;
          r.ftime = sched_time[idx];
          r.ftag = sched_tag[idx];
        end
      end
      CMD_FIND: begin
        for (i = 0; i < entry_total; i++) begin
          if (sched_time[i] == c.dtime) begin
            r.status = ST_OK;
            r.ftime = sched_time[i];
            r.ftag = sched_tag[i];
            break;
          end
        end
      end
      default: begin
        if (locate_slot(c.off, idx)) begin
          for (i = idx; i + 1 < entry_total; i++) begin
            sched_time[i] = sched_time[i+1];
            sched_tag[i] = sched_tag[i+1];
          end
          entry_total--;
          r.status = ST_OK;
        end
      end
    endcase
    r.count = CNT_PORT_W'(entry_total);
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                           input logic [TAG_PORT_W-1:0] tag, input logic signed [OFF_W-1:0] off);
    queue_cmd_t c;
    c.cmd = cmd;
    c.dtime = t;
    c.tag = tag;
    c.off = off;
    pending_cmds.push_back(c);
    queued_items++;
  endtask

  // Times mostly from a narrow range so equal keys are common
  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(99);
    if (r < 65) return TIME_W'($urandom_range(0, 47));
    if (r < 75) return 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 7));
    if (r < 80) return (r < 78) ? 32'h0 : 32'hFFFF_FFFF;
    return TIME_W'($urandom);
  endfunction

  // Offsets mostly near the reachable range of the current table
  function automatic logic signed [OFF_W-1:0] pick_offset();
    int v;
    if (entry_total > 0 && $urandom_range(99) < 80) begin
      v = int'($urandom_range(0, 2 * entry_total)) - entry_total;
      return v[OFF_W-1:0];
    end
    return OFF_W'($urandom_range(127));
  endfunction

  task automatic queue_random_cmd(input mix_t mix);
    int r;
    int ins_w;
    int peek_w;
    int find_w;
    logic [CMD_W-1:0] cmd;
    logic [TIME_W-1:0] t;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:     begin ins_w = 70; peek_w = 10; find_w = 10; end
      MIX_DRAIN:    begin ins_w = 10; peek_w = 15; find_w = 15; end
      default:      begin ins_w = 35; peek_w = 25; find_w = 20; end
    endcase
    if (r < ins_w) cmd = CMD_INSERT;
    else if (r < ins_w + peek_w) cmd = CMD_PEEK;
    else if (r < ins_w + peek_w + find_w) cmd = CMD_FIND;
    else cmd = CMD_DELETE;
    t = pick_time();
    // Half the finds look up a key known to be stored
    if (cmd == CMD_FIND && entry_total > 0 && $urandom_range(1) == 1)
      t = sched_time[$urandom_range(0, entry_total - 1)];
    queue_cmd(cmd, t, TAG_PORT_W'($urandom_range(65535)), pick_offset());
  endtask

  // Driver: predict on acceptance, then present the next pending item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_cmd.cmd = in_command;
        next_cmd.dtime = in_departure_time;
        next_cmd.tag = in_entry_tag;
        next_cmd.off = in_position_offset;
        apply_command(next_cmd);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && (quiet_stretch || $urandom_range(99) >= 25)) begin
          next_cmd = pending_cmds.pop_front();
          in_command <= next_cmd.cmd;
          in_departure_time <= next_cmd.dtime;
          in_entry_tag <= next_cmd.tag;
          in_position_offset <= next_cmd.off;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, a stretch with none
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_stretch && ($urandom_range(99) < 25);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        queue_result_t e;
        e = expected_results.pop_front();
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, e.status));
        if (out_found_time !== e.ftime)
          report_mismatch($sformatf("found_time %h, expected %h", out_found_time, e.ftime));
        if (out_found_tag !== e.ftag)
          report_mismatch($sformatf("found_tag %h, expected %h", out_found_tag, e.ftag));
        if (out_entry_count !== e.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", out_entry_count, e.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus and end of test
  initial begin
    mix_t mix;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: every lookup and delete misses
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, 7'sd0);
    queue_cmd(CMD_FIND,   32'h0, 16'h0, 7'sd0);
    queue_cmd(CMD_DELETE, 32'h0, 16'h0, -7'sd1);
    // Single entry: negative offsets never wrap onto it
    queue_cmd(CMD_INSERT, 32'd100, 16'hFFFF, 7'sd0);
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, -7'sd1);
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, 7'sd0);
    // Extreme times and an equal time that must land after its twin
    queue_cmd(CMD_INSERT, 32'h0, 16'h0000, 7'sd0);
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'h1234, 7'sd0);
    queue_cmd(CMD_INSERT, 32'd100, 16'hAAAA, 7'sd0);
    queue_cmd(CMD_FIND,   32'd100, 16'h0, 7'sd0);
    queue_cmd(CMD_FIND,   32'd5, 16'h0, 7'sd0);
    queue_cmd(CMD_FIND,   32'hFFFF_FFFF, 16'h0, 7'sd0);
    // Offsets at and just past both ends
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, -7'sd1);
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, -7'sd3);
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, -7'sd4);
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, 7'sd3);
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, 7'sd4);
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, 7'sd63);
    queue_cmd(CMD_PEEK,   32'h0, 16'h0, -7'sd64);
    queue_cmd(CMD_DELETE, 32'h0, 16'h0, -7'sd1);
    queue_cmd(CMD_DELETE, 32'h0, 16'h0, 7'sd63);
    queue_cmd(CMD_DELETE, 32'h0, 16'h0, -7'sd64);
    queue_cmd(CMD_DELETE, 32'h0, 16'h0, 7'sd0);

    // Random part in blocks that fill, churn and drain the table
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      while (pending_cmds.size() != 0) @(negedge clk);
      case ((i / 100) % 3)
        0: mix = MIX_FILL;
        1: mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      queue_random_cmd(mix);
    end

    while (accepted_items != queued_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
